// ===== sv/float_matrix_to_fixed_pack_top_macros.svh =====
// assertion macros for the float matrix to fixed pack block
`ifndef FLOAT_MATRIX_TO_FIXED_PACK_TOP_MACROS_SVH
`define FLOAT_MATRIX_TO_FIXED_PACK_TOP_MACROS_SVH

// assert a property under clk, disabled during reset
`define FMP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// assert that one condition implies another in the next cycle
`define FMP_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ===== sv/fmp_pkg.sv =====
// package: types and constants for the float matrix to fixed pack block
`default_nettype none
package fmp_pkg;
	localparam int unsigned LANES = 4;
	localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;
	localparam logic [7:0] EXP_SPECIAL = 8'hFF;

	typedef struct packed {
		logic [1:0]  row_index;
		logic [31:0] elem_0;
		logic [31:0] elem_1;
		logic [31:0] elem_2;
		logic [31:0] elem_3;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  out_row;
		logic [31:0] int_word_a;
		logic [31:0] int_word_b;
		logic [31:0] frac_word_a;
		logic [31:0] frac_word_b;
		logic [3:0]  clamp_mask;
	} out_word_t;

	typedef struct packed {
		logic [31:0] fixed;
		logic        clamped;
	} lane_res_t;
endpackage
`default_nettype wire

// ===== sv/float_matrix_to_fixed_pack_top.sv =====
// top level: four conversion lanes and a registered split-pack merge
//
//  channel | handshake        | payload
//  input   | start, busy      | in_word  (in_word_t)
//  output  | result_valid     | result   (out_word_t)
//
// one row per cycle: the lanes and packing sit before
// the single result register
// busy is held low; the block never stalls its sender
// result is on the ports for one cycle with result_valid; no receiver stall
// reset clears only result_valid
`default_nettype none
`include "float_matrix_to_fixed_pack_top_macros.svh"
module float_matrix_to_fixed_pack_top import fmp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire in_word_t  in_word,
	output logic           result_valid,
	output out_word_t      result
);
	lane_res_t lane_res [LANES];
	out_word_t packed_w;
	logic      valid_q;
	out_word_t result_q;

	// the four lanes, one per column
	fmp_lane u_lane0 (.bits(in_word.elem_0), .res(lane_res[0]));
	fmp_lane u_lane1 (.bits(in_word.elem_1), .res(lane_res[1]));
	fmp_lane u_lane2 (.bits(in_word.elem_2), .res(lane_res[2]));
	fmp_lane u_lane3 (.bits(in_word.elem_3), .res(lane_res[3]));

	// merge: integer halves in two words, fraction halves in two others
	always_comb begin
		packed_w.out_row     = in_word.row_index;
		packed_w.int_word_a  = {lane_res[0].fixed[31:16], lane_res[1].fixed[31:16]};
		packed_w.int_word_b  = {lane_res[2].fixed[31:16], lane_res[3].fixed[31:16]};
		packed_w.frac_word_a = {lane_res[0].fixed[15:0], lane_res[1].fixed[15:0]};
		packed_w.frac_word_b = {lane_res[2].fixed[15:0], lane_res[3].fixed[15:0]};
		packed_w.clamp_mask  = {lane_res[3].clamped, lane_res[2].clamped,
			lane_res[1].clamped, lane_res[0].clamped};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= start && !busy;
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			result_q <= packed_w;
		end
	end

	assign busy         = 1'b0;
	assign result_valid = valid_q;
	assign result       = result_q;

	`FMP_ASSERT_NEXT(a_valid_follows, start && !busy, result_valid, "accepted word gave no result")
	`FMP_ASSERT_NEXT(a_no_spurious, !start, !result_valid, "result without accepted word")
	`FMP_ASSERT_NEXT(a_row_echo, start && !busy, result.out_row == $past(in_word.row_index), "row echo wrong")
endmodule
`default_nettype wire

// ===== sv/fmp_lane.sv =====
// one conversion lane: float bit pattern to saturated s15.16
`default_nettype none
module fmp_lane import fmp_pkg::*; (
	input  wire logic [31:0] bits,
	output lane_res_t        res
);
	logic        neg;
	logic [7:0]  expo;
	logic [23:0] man;
	logic [40:0] mag;
	logic [8:0]  sh;

	always_comb begin
		neg  = bits[31];
		expo = bits[30:23];
		man  = (expo == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
		mag  = '0;
		sh   = '0;
		res  = '{fixed: 32'd0, clamped: 1'b0};
		// exponent 134 is the point where the mantissa lands unshifted
		if (expo >= 8'd150) begin
			mag = 41'h100_0000_0000;
		end else if (expo >= 8'd134) begin
			sh  = {1'b0, expo} - 9'd134;
			mag = {17'd0, man} << sh[3:0];
		end else if (expo > 8'd102) begin
			sh  = 9'd134 - {1'b0, expo};
			mag = {17'd0, man >> sh[4:0]};
		end
		if (expo == EXP_SPECIAL) begin
			res.clamped = 1'b1;
			res.fixed   = (bits[22:0] != 23'd0) ? 32'd0 : (neg ? NEG_LIMIT : POS_LIMIT);
		end else if (mag != 41'd0) begin
			if (neg) begin
				if (mag > {9'd0, NEG_LIMIT}) begin
					res = '{fixed: NEG_LIMIT, clamped: 1'b1};
				end else begin
					res.fixed = 32'd0 - mag[31:0];
				end
			end else if (mag > {9'd0, POS_LIMIT}) begin
				res = '{fixed: POS_LIMIT, clamped: 1'b1};
			end else begin
				res.fixed = mag[31:0];
			end
		end
	end
endmodule
`default_nettype wire
